// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the stream statistics block.
// Depends on nothing; included by the files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SMMM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SMMM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/smmm_pkg.sv =====
// Package of the stream statistics block: field widths and ALU operation codes.
// Depends on nothing; used by the ALU and the top level.
`timescale 1ns / 1ps

package smmm_pkg;

	// Fixed widths of the item fields.
	localparam int SAMPLE_W = 5;
	localparam int FRAC_W   = 4;
	localparam int MEAN_W   = SAMPLE_W + FRAC_W;
	localparam int FREQ_W   = 9;

	// Shared ALU operations.
	typedef logic [0:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 1'b0;
	localparam alu_op_t ALU_SUB = 1'b1;

endpackage

// ===== rtl/core/stream_min_max_mean_mode_top.sv =====
// Top level of the stream statistics block: sequencer, running registers,
// histogram RAM and shared ALU. Uses smmm_pkg, smmm_ram, smmm_alu and assert_macros.svh.
//
// Usage: samples arrive on the sample channel (sample_valid/sample_ready), one
// item per sample, with is_last set on the final sample of a set. For each set
// one item leaves on the result channel (result_valid/result_ready): minimum,
// maximum, mean with four fraction bits (truncated), mode (smallest value on
// ties) with its frequency, and a flag for samples dropped past MAX_SAMPLES.
// Steps: a sample that is accumulated passes accept, bin read and bin write
// (through the RAM's registered read port); a sample past MAX_SAMPLES is only
// flagged. A last sample then adds a bin scan (read, then compare in the shared
// ALU per bin), restoring division on the same ALU and the load of the result register.
// The result register frees the sequencer: a new set may start while a result
// waits; if the next set ends before the result is taken, the block waits in
// its last step until result_ready. Reset clears all counters and the bin
// valid bits at once, so no clearing pass is needed.
`timescale 1ns / 1ps

module stream_min_max_mean_mode_top
	import smmm_pkg::*;
#(
	parameter int MAX_VALUE   = 31,
	parameter int MAX_SAMPLES = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  logic [SAMPLE_W-1:0] sample_value,
	input  logic                is_last,
	output logic                result_valid,
	input  logic                result_ready,
	output logic [SAMPLE_W-1:0] min_value,
	output logic [SAMPLE_W-1:0] max_value,
	output logic [MEAN_W-1:0]   mean_fixed,
	output logic [SAMPLE_W-1:0] mode_value,
	output logic [FREQ_W-1:0]   mode_frequency,
	output logic                overflowed
);

`include "assert_macros.svh"

	localparam int BC   = MAX_VALUE + 1;
	localparam int VW   = $clog2(BC);
	localparam int CW   = $clog2(MAX_SAMPLES + 1);
	localparam int SW   = CW + SAMPLE_W;
	localparam int DCW  = $clog2(MEAN_W);
	localparam logic [CW-1:0]  MAX_CNT  = CW'(MAX_SAMPLES);
	localparam logic [VW-1:0]  TOP_BIN  = VW'(MAX_VALUE);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(MEAN_W - 1);

	// Sequencer state codes.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ACC  = 3'd1;
	localparam logic [2:0] ST_INC  = 3'd2;
	localparam logic [2:0] ST_SRD  = 3'd3;
	localparam logic [2:0] ST_SCMP = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FIN  = 3'd6;

	logic [2:0]        state_q;
	logic [VW-1:0]     v_q;
	logic              last_q;
	logic [CW-1:0]     count_q;
	logic [SW-1:0]     sum_q;
	logic [VW-1:0]     min_q;
	logic [VW-1:0]     max_q;
	logic              drop_q;
	logic [BC-1:0]     bin_valid_q;
	logic [VW-1:0]     idx_q;
	logic [CW-1:0]     freq_q;
	logic [VW-1:0]     mode_q;
	logic [CW-1:0]     rem_q;
	logic [MEAN_W-1:0] low_q;
	logic [MEAN_W-1:0] quo_q;
	logic [DCW-1:0]    div_cnt_q;
	logic              result_valid_q;

	logic [VW-1:0]     sat_value;
	logic              accept;
	logic              full_set;
	logic              load_out;
	logic [VW-1:0]     ram_raddr;
	logic [CW-1:0]     ram_rdata;
	logic              ram_we;
	logic [CW-1:0]     bin_old;
	logic [CW-1:0]     bin_scan;
	logic [CW:0]       div_trial;
	alu_op_t           alu_op;
	logic [SW-1:0]     alu_a;
	logic [SW-1:0]     alu_b;
	logic [SW-1:0]     alu_res;
	logic              alu_carry;

	// Handshake and sample saturation.
	assign sample_ready = (state_q == ST_IDLE);
	assign accept       = sample_valid && sample_ready;
	assign full_set     = (count_q >= MAX_CNT);
	assign sat_value    = (int'(sample_value) > MAX_VALUE) ? TOP_BIN : VW'(sample_value);
	assign load_out     = (state_q == ST_FIN) && (!result_valid_q || result_ready);

	// Bins never written since the last clear read as zero.
	assign bin_old  = bin_valid_q[v_q] ? ram_rdata : '0;
	assign bin_scan = bin_valid_q[idx_q] ? ram_rdata : '0;
	assign div_trial = {rem_q, low_q[MEAN_W-1]};

	// Histogram RAM: read at the sample in ACC, at the scan index otherwise.
	assign ram_raddr = (state_q == ST_ACC) ? v_q : idx_q;
	assign ram_we    = (state_q == ST_INC);

	smmm_ram #(
		.WIDTH(CW),
		.DEPTH(BC)
	) u_bins (
		.clk  (clk),
		.we   (ram_we),
		.waddr(v_q),
		.wdata(alu_res[CW-1:0]),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Operand selection for the shared ALU.
	always_comb begin
		case (state_q)
			ST_ACC: begin
				alu_op = ALU_ADD;
				alu_a  = sum_q;
				alu_b  = SW'(v_q);
			end
			ST_INC: begin
				alu_op = ALU_ADD;
				alu_a  = SW'(bin_old);
				alu_b  = SW'(1'b1);
			end
			ST_SCMP: begin
				alu_op = ALU_SUB;
				alu_a  = SW'(freq_q);
				alu_b  = SW'(bin_scan);
			end
			ST_DIV: begin
				alu_op = ALU_SUB;
				alu_a  = SW'(div_trial);
				alu_b  = SW'(count_q);
			end
			default: begin
				alu_op = ALU_ADD;
				alu_a  = '0;
				alu_b  = '0;
			end
		endcase
	end

	smmm_alu #(
		.W(SW)
	) u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.result(alu_res),
		.carry (alu_carry)
	);

	// Sequencer and running registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			sum_q       <= '0;
			min_q       <= TOP_BIN;
			max_q       <= '0;
			drop_q      <= 1'b0;
			bin_valid_q <= '0;
			idx_q       <= '0;
			freq_q      <= '0;
			mode_q      <= '0;
			div_cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						v_q    <= sat_value;
						last_q <= is_last;
						if (full_set) begin
							drop_q <= 1'b1;
							if (is_last) begin
								idx_q   <= '0;
								freq_q  <= '0;
								mode_q  <= '0;
								state_q <= ST_SRD;
							end
						end else begin
							count_q <= count_q + 1'b1;
							if (sat_value < min_q) begin
								min_q <= sat_value;
							end
							if (sat_value > max_q) begin
								max_q <= sat_value;
							end
							state_q <= ST_ACC;
						end
					end
				end
				ST_ACC: begin
					sum_q   <= alu_res;
					state_q <= ST_INC;
				end
				ST_INC: begin
					bin_valid_q[v_q] <= 1'b1;
					if (last_q) begin
						idx_q   <= '0;
						freq_q  <= '0;
						mode_q  <= '0;
						state_q <= ST_SRD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_SRD: begin
					state_q <= ST_SCMP;
				end
				ST_SCMP: begin
					// A borrow means the held frequency is strictly below this bin.
					if (alu_carry) begin
						freq_q <= bin_scan;
						mode_q <= idx_q;
					end
					if (idx_q == TOP_BIN) begin
						rem_q     <= sum_q[SW-1:SAMPLE_W];
						low_q     <= {sum_q[SAMPLE_W-1:0], {FRAC_W{1'b0}}};
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_SRD;
					end
				end
				ST_DIV: begin
					// One restoring division step: keep the difference when it fits.
					if (alu_carry) begin
						rem_q <= div_trial[CW-1:0];
					end else begin
						rem_q <= alu_res[CW-1:0];
					end
					quo_q <= {quo_q[MEAN_W-2:0], !alu_carry};
					low_q <= {low_q[MEAN_W-2:0], 1'b0};
					if (div_cnt_q == DIV_LAST) begin
						state_q <= ST_FIN;
					end else begin
						div_cnt_q <= div_cnt_q + 1'b1;
					end
				end
				ST_FIN: begin
					if (load_out) begin
						count_q     <= '0;
						sum_q       <= '0;
						min_q       <= TOP_BIN;
						max_q       <= '0;
						drop_q      <= 1'b0;
						bin_valid_q <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result register: holds the item until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			min_value      <= SAMPLE_W'(min_q);
			max_value      <= SAMPLE_W'(max_q);
			mean_fixed     <= (count_q == '0) ? '0 : quo_q;
			mode_value     <= SAMPLE_W'(mode_q);
			mode_frequency <= FREQ_W'(freq_q);
			overflowed     <= drop_q;
		end
	end

	assign result_valid = result_valid_q;

	// Checks on the sequencer and the running registers.
	`SMMM_ASSERT_NEXT(a_clear_after_result, clk, arst_n, load_out,
		(count_q == '0) && (bin_valid_q == '0) && !drop_q, "set state not cleared after result")
	`SMMM_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= MAX_CNT,
		"sample count above its limit")
	`SMMM_ASSERT_NOW(a_min_le_max, clk, arst_n, count_q != '0, min_q <= max_q,
		"running minimum above running maximum")
	`SMMM_ASSERT_NOW(a_freq_le_count, clk, arst_n, load_out, freq_q <= count_q,
		"mode frequency above sample count")

endmodule

// ===== rtl/core/smmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing; holds the histogram bins of the statistics block.
`timescale 1ns / 1ps

module smmm_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/smmm_alu.sv =====
// Shared add/subtract unit of the statistics block, used for the running sum,
// bin increments, the mode compare and the division steps. Uses smmm_pkg.
`timescale 1ns / 1ps

module smmm_alu
	import smmm_pkg::*;
#(
	parameter int W = 14
) (
	input  alu_op_t      op,
	input  logic [W-1:0] a,
	input  logic [W-1:0] b,
	output logic [W-1:0] result,
	output logic         carry
);

	logic [W:0] full;

	// Carry out on add, borrow out on subtract.
	always_comb begin
		case (op)
			ALU_ADD: full = {1'b0, a} + {1'b0, b};
			ALU_SUB: full = {1'b0, a} - {1'b0, b};
			default: full = '0;
		endcase
	end

	assign result = full[W-1:0];
	assign carry  = full[W];

endmodule
